// ===== hw/rtl/sorted_memory_region_table_top_macros.svh =====
// assertion macros for the sorted memory region table checker
// expects signals named clk and rst_n in the scope of use
`ifndef SORTED_MEMORY_REGION_TABLE_TOP_MACROS_SVH
`define SORTED_MEMORY_REGION_TABLE_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define SMRT_ASSERT_IMM(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("port check failed");

// next-cycle implication, disabled in reset
`define SMRT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("port check failed");

`endif

// ===== hw/rtl/smrt_pkg.sv =====
// shared types and constants for the sorted memory region table
// no dependencies
package smrt_pkg;

  localparam int DEF_MAX_REGIONS = 16;

  localparam logic [63:0] LOW_MIB     = 64'h0000_0000_0010_0000;
  localparam logic [63:0] FOUR_GIB    = 64'h0000_0001_0000_0000;
  localparam logic [31:0] TYPE_USABLE = 32'd1;

  typedef enum logic [1:0] {
    CMD_ADD,
    CMD_FIND,
    CMD_NEXT,
    CMD_NONE
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_SKIP,
    ST_OVERFLOW,
    ST_NOTFOUND
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SPLIT,
    S_INS_INIT,
    S_INS_CHK,
    S_INS_CMP,
    S_SCAN_CHK,
    S_SCAN_CMP,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic prep;
    logic split;
    logic ins_init;
    logic ins_full;
    logic ins_rd;
    logic ins_shift;
    logic ins_place;
    logic next_part;
    logic scan_init;
    logic scan_rd;
    logic scan_step;
    logic scan_next_tab;
    logic hit;
    logic finish;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    cmd_t cmd;
    logic skip;
    logic full;
    logic have_more;
    logic idx_zero;
    logic rd_gt;
    logic scan_end;
    logic tab_upper;
    logic rd_match;
  } sts_t;

  typedef struct packed {
    logic [63:0] start;
    logic [63:0] len;
  } entry_t;

endpackage

// ===== hw/rtl/smrt_ctrl.sv =====
// sequencer for the sorted memory region table
// depends on smrt_pkg
module smrt_ctrl import smrt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  sts_t sts,
  output ctl_t ctl
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        unique case (sts.cmd)
          CMD_ADD:  state_nxt = sts.skip ? S_DONE : S_SPLIT;
          CMD_FIND: state_nxt = S_SCAN_CHK;
          CMD_NEXT: state_nxt = S_SCAN_CHK;
          CMD_NONE: state_nxt = S_DONE;
        endcase
      end
      S_SPLIT: state_nxt = S_INS_INIT;
      S_INS_INIT: begin
        if (sts.full) begin
          state_nxt = sts.have_more ? S_INS_INIT : S_DONE;
        end else begin
          state_nxt = S_INS_CHK;
        end
      end
      S_INS_CHK: begin
        if (sts.idx_zero) begin
          state_nxt = sts.have_more ? S_INS_INIT : S_DONE;
        end else begin
          state_nxt = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (sts.rd_gt) begin
          state_nxt = S_INS_CHK;
        end else begin
          state_nxt = sts.have_more ? S_INS_INIT : S_DONE;
        end
      end
      S_SCAN_CHK: begin
        if (sts.scan_end) begin
          state_nxt = sts.tab_upper ? S_DONE : S_SCAN_CHK;
        end else begin
          state_nxt = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: state_nxt = sts.rd_match ? S_DONE : S_SCAN_CHK;
      S_DONE:     state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctl  = '0;
    busy = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: ctl.load = start;
      S_DECODE: begin
        ctl.prep      = 1'b1;
        ctl.scan_init = (sts.cmd == CMD_FIND) || (sts.cmd == CMD_NEXT);
      end
      S_SPLIT: ctl.split = 1'b1;
      S_INS_INIT: begin
        if (sts.full) begin
          ctl.ins_full  = 1'b1;
          ctl.next_part = sts.have_more;
        end else begin
          ctl.ins_init = 1'b1;
        end
      end
      S_INS_CHK: begin
        if (sts.idx_zero) begin
          ctl.ins_place = 1'b1;
          ctl.next_part = sts.have_more;
        end else begin
          ctl.ins_rd = 1'b1;
        end
      end
      S_INS_CMP: begin
        if (sts.rd_gt) begin
          ctl.ins_shift = 1'b1;
        end else begin
          ctl.ins_place = 1'b1;
          ctl.next_part = sts.have_more;
        end
      end
      S_SCAN_CHK: begin
        if (sts.scan_end) begin
          ctl.scan_next_tab = !sts.tab_upper;
        end else begin
          ctl.scan_rd = 1'b1;
        end
      end
      S_SCAN_CMP: begin
        if (sts.rd_match) begin
          ctl.hit = 1'b1;
        end else begin
          ctl.scan_step = 1'b1;
        end
      end
      S_DONE:  ctl.finish = 1'b1;
      default: ctl = '0;
    endcase
  end

endmodule

// ===== hw/rtl/smrt_dp.sv =====
// datapath for the sorted memory region table: entry filter, split, two table memories
// depends on smrt_pkg
module smrt_dp import smrt_pkg::*; #(
  parameter int MAX_REGIONS = DEF_MAX_REGIONS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  ctl_t        ctl,
  output sts_t        sts,
  input  logic [1:0]  in_command,
  input  logic [63:0] in_base_addr,
  input  logic [63:0] in_region_len,
  input  logic [31:0] in_entry_type,
  input  logic [63:0] in_query_addr,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [63:0] out_region_start,
  output logic [63:0] out_region_length
);

  localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CNT_W = $clog2(MAX_REGIONS + 1);

  // captured beat
  cmd_t        cmd_r;
  logic [63:0] base_r, len_r, query_r;
  logic [31:0] type_r;
  logic [64:0] sum_r;

  // stretched region
  logic [63:0] st_r, ln_r, end_r;
  logic        endc_r;

  // parts after split
  logic [63:0] a_len_r, b_len_r;
  logic        a_upper_r, have_b_r, part_b_r;

  logic             tab_r;
  logic [CNT_W-1:0] idx_r;
  logic [CNT_W-1:0] cnt_r [2];
  logic             ovf_r, found_r;
  logic [63:0]      res_start_r, res_len_r;

  entry_t lo_mem [MAX_REGIONS];
  entry_t up_mem [MAX_REGIONS];
  entry_t lo_rd_r, up_rd_r, rd_q, wdata;

  logic             out_valid_r;
  status_t          out_status_r;
  logic [63:0]      out_start_r, out_len_r;

  logic             skip, stretch, split;
  logic [63:0]      stretch_len, low_size;
  logic [63:0]      cur_start, cur_len;
  logic             cur_upper;
  logic [CNT_W-1:0] idx_m1;
  logic [IDX_W-1:0] waddr, raddr;
  logic             mem_we, mem_re;

  assign skip = (type_r != TYPE_USABLE) || (!sum_r[64] && (sum_r[63:0] <= LOW_MIB));
  assign stretch     = (base_r <= LOW_MIB);
  assign stretch_len = sum_r[64] ? '1 : sum_r[63:0];
  assign split       = (st_r < FOUR_GIB) && (endc_r || (end_r > FOUR_GIB));
  assign low_size    = FOUR_GIB - st_r;

  assign cur_start = part_b_r ? FOUR_GIB : st_r;
  assign cur_len   = part_b_r ? b_len_r  : a_len_r;
  assign cur_upper = part_b_r | a_upper_r;

  assign idx_m1 = idx_r - CNT_W'(1);
  assign waddr  = idx_r[IDX_W-1:0];
  assign raddr  = ctl.ins_rd ? idx_m1[IDX_W-1:0] : idx_r[IDX_W-1:0];
  assign mem_we = ctl.ins_shift | ctl.ins_place;
  assign mem_re = ctl.ins_rd | ctl.scan_rd;
  assign rd_q   = tab_r ? up_rd_r : lo_rd_r;
  assign wdata  = ctl.ins_shift ? rd_q : entry_t'{start: cur_start, len: cur_len};

  always_comb begin
    sts           = '0;
    sts.cmd       = cmd_r;
    sts.skip      = skip;
    sts.full      = (cnt_r[cur_upper] == CNT_W'(MAX_REGIONS));
    sts.have_more = have_b_r & ~part_b_r;
    sts.idx_zero  = (idx_r == '0);
    sts.rd_gt     = (rd_q.start > cur_start);
    sts.scan_end  = (idx_r == cnt_r[tab_r]);
    sts.tab_upper = tab_r;
    if (cmd_r == CMD_FIND) begin
      sts.rd_match = (query_r >= rd_q.start) && ((query_r - rd_q.start) < rd_q.len);
    end else begin
      sts.rd_match = (rd_q.start > query_r);
    end
  end

  // table memories
  always_ff @(posedge clk) begin
    if (mem_we && !tab_r) lo_mem[waddr] <= wdata;
    if (mem_we && tab_r) up_mem[waddr] <= wdata;
    if (mem_re) begin
      lo_rd_r <= lo_mem[raddr];
      up_rd_r <= up_mem[raddr];
    end
  end

  // payload and sequencing registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r   <= cmd_t'(in_command);
      base_r  <= in_base_addr;
      len_r   <= in_region_len;
      type_r  <= in_entry_type;
      query_r <= in_query_addr;
      sum_r   <= {1'b0, in_base_addr} + {1'b0, in_region_len};
      found_r <= 1'b0;
      ovf_r   <= 1'b0;
    end
    if (ctl.prep) begin
      st_r   <= stretch ? '0 : base_r;
      ln_r   <= stretch ? stretch_len : len_r;
      end_r  <= stretch ? stretch_len : sum_r[63:0];
      endc_r <= stretch ? 1'b0 : sum_r[64];
    end
    if (ctl.split) begin
      a_len_r   <= split ? low_size : ln_r;
      a_upper_r <= split ? 1'b0 : (st_r >= FOUR_GIB);
      have_b_r  <= split;
      b_len_r   <= ln_r - low_size;
      part_b_r  <= 1'b0;
    end
    if (ctl.next_part) part_b_r <= 1'b1;
    if (ctl.ins_full) ovf_r <= 1'b1;
    if (ctl.hit) begin
      found_r     <= 1'b1;
      res_start_r <= rd_q.start;
      res_len_r   <= rd_q.len;
    end
    if (ctl.ins_init) begin
      tab_r <= cur_upper;
      idx_r <= cnt_r[cur_upper];
    end else if (ctl.ins_shift) begin
      idx_r <= idx_m1;
    end else if (ctl.scan_init) begin
      tab_r <= 1'b0;
      idx_r <= '0;
    end else if (ctl.scan_next_tab) begin
      tab_r <= 1'b1;
      idx_r <= '0;
    end else if (ctl.scan_step) begin
      idx_r <= idx_r + CNT_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      out_start_r <= '0;
      out_len_r   <= '0;
      unique case (cmd_r)
        CMD_ADD: begin
          priority if (skip)  out_status_r <= ST_SKIP;
          else if (ovf_r)     out_status_r <= ST_OVERFLOW;
          else                out_status_r <= ST_OK;
        end
        CMD_FIND, CMD_NEXT: begin
          if (found_r) begin
            out_status_r <= ST_OK;
            out_start_r  <= res_start_r;
            out_len_r    <= res_len_r;
          end else begin
            out_status_r <= ST_NOTFOUND;
          end
        end
        CMD_NONE: out_status_r <= ST_SKIP;
      endcase
    end
  end

  // region counts and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r[0]    <= '0;
      cnt_r[1]    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl.finish;
      if (ctl.ins_place) cnt_r[tab_r] <= cnt_r[tab_r] + CNT_W'(1);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_region_start  = out_start_r;
  assign out_region_length = out_len_r;

endmodule

// ===== hw/rtl/sorted_memory_region_table_top.sv =====
// sorted memory region table, top level; uses smrt_pkg, smrt_ctrl, smrt_dp
// one command at a time; a new command can be taken while the last one's result beat shows
// find/next: decode, then a check and a compare per entry visited, a check per table ended
// add: a dropped entry goes from decode to done; else decode, split, then per part a full
//   check or an init and a walk down that moves each greater start up; receiver cannot stall
// rst_n synchronous active low: tables empty, sequencer idle, no result pending
module sorted_memory_region_table_top import smrt_pkg::*; #(
  parameter int MAX_REGIONS = DEF_MAX_REGIONS
) (
  input  logic        clk,
  input  logic        rst_n,
  // command beat
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [63:0] in_base_addr,
  input  logic [63:0] in_region_len,
  input  logic [31:0] in_entry_type,
  input  logic [63:0] in_query_addr,
  // result beat
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [63:0] out_region_start,
  output logic [63:0] out_region_length
);

  // command and status between sequencer and datapath
  ctl_t ctl;
  sts_t sts;

  // sequencer: decode, insert walk from the top of a table, linear scan lower then upper
  smrt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .ctl   (ctl)
  );

  // datapath: filter, stretch to zero, split at 4 GiB, two sorted region memories
  smrt_dp #(
    .MAX_REGIONS (MAX_REGIONS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .sts               (sts),
    .in_command        (in_command),
    .in_base_addr      (in_base_addr),
    .in_region_len     (in_region_len),
    .in_entry_type     (in_entry_type),
    .in_query_addr     (in_query_addr),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_region_start  (out_region_start),
    .out_region_length (out_region_length)
  );

endmodule

// ===== hw/rtl/smrt_checker.sv =====
// port-level checks for the sorted memory region table, bound to the top level
// depends on smrt_pkg and sorted_memory_region_table_top_macros.svh
`include "sorted_memory_region_table_top_macros.svh"

module smrt_checker import smrt_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_command,
  input logic [63:0] in_base_addr,
  input logic [63:0] in_region_len,
  input logic [31:0] in_entry_type,
  input logic [63:0] in_query_addr,
  input logic        out_valid,
  input logic [1:0]  out_status,
  input logic [63:0] out_region_start,
  input logic [63:0] out_region_length
);

  // result beat only once the command has finished
  `SMRT_ASSERT_IMM(a_valid_not_busy, out_valid, !busy)
  // an accepted command keeps the block busy
  `SMRT_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  // no result beat right after an accept
  `SMRT_ASSERT_NXT(a_accept_no_result, start && !busy, !out_valid)
  // region fields are zero unless a region was found
  `SMRT_ASSERT_IMM(a_zero_fields, out_valid && (out_status != ST_OK), (out_region_start == '0) && (out_region_length == '0))

endmodule

bind sorted_memory_region_table_top smrt_checker u_smrt_checker (.*);

// ===== tb/tb_sorted_memory_region_table_top.sv =====
`timescale 1ns / 100ps
// self-checking testbench for sorted_memory_region_table_top: directed and random commands
// depends on smrt_pkg and the rtl of sorted_memory_region_table_top, nothing else
module tb_sorted_memory_region_table_top;
  import smrt_pkg::*;

  localparam int TABLE_DEPTH = DEF_MAX_REGIONS;
  localparam int LOWER = 0;
  localparam int UPPER = 1;
  localparam int TOTAL_ITEMS = 1450;
  // worst case per beat: the longest command plus the longest idle gap, taken several times over
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 4 * TABLE_DEPTH + 16;
  localparam int PRINT_CAP = 100;

  // one expected result beat, tagged with the cycle its command was taken
  typedef struct {
    status_t     status;
    logic [63:0] reg_start;
    logic [63:0] reg_len;
    int unsigned acc_cyc;
  } region_beat_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_command;
  logic [63:0] in_base_addr;
  logic [63:0] in_region_len;
  logic [31:0] in_entry_type;
  logic [63:0] in_query_addr;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [63:0] out_region_start;
  logic [63:0] out_region_length;

  // shadow copy of both region tables, index LOWER or UPPER
  logic [63:0] tab_start [2][TABLE_DEPTH];
  logic [63:0] tab_len   [2][TABLE_DEPTH];
  int          tab_cnt   [2];

  region_beat_t pending_regions[$];
  int unsigned  cyc = 0;
  int           err_cnt = 0;
  int           items_sent = 0;
  bit           no_idle = 0;

  sorted_memory_region_table_top #(.MAX_REGIONS(TABLE_DEPTH)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_base_addr     (in_base_addr),
    .in_region_len    (in_region_len),
    .in_entry_type    (in_entry_type),
    .in_query_addr    (in_query_addr),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_region_start (out_region_start),
    .out_region_length(out_region_length)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // cycle count, updated late in the step so every process sees the pre-edge value
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cyc);
      $display("tb_sorted_memory_region_table_top: errors");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    err_cnt++;
    // keep the log bounded when the block is badly broken
    if (err_cnt <= PRINT_CAP) $display("%0t mismatch: %s", $time, what);
  endtask

  // ---------------------------------------------------------------- predictor

  // sorted insert: goes before the first strictly greater start, so equal starts keep order
  function automatic bit table_insert(input int t, input logic [63:0] s, input logic [63:0] l);
    int pos;
    int i;
    if (tab_cnt[t] >= TABLE_DEPTH) return 1'b0;
    pos = tab_cnt[t];
    for (i = 0; i < tab_cnt[t]; i++) begin
      if (tab_start[t][i] > s) begin
        pos = i;
        break;
      end
    end
    for (i = tab_cnt[t]; i > pos; i--) begin
      tab_start[t][i] = tab_start[t][i-1];
      tab_len[t][i]   = tab_len[t][i-1];
    end
    tab_start[t][pos] = s;
    tab_len[t][pos]   = l;
    tab_cnt[t]++;
    return 1'b1;
  endfunction

  function automatic status_t predict_add(input logic [63:0] base, input logic [63:0] len,
                                          input logic [31:0] typ);
    logic [64:0] end65;
    logic [63:0] rstart;
    logic [63:0] rlen;
    logic [63:0] below;
    bit          ok;
    // end address carried on 65 bits so a wrap past 2^64 still counts as high
    end65 = {1'b0, base} + {1'b0, len};
    if (typ != TYPE_USABLE || end65 <= {1'b0, LOW_MIB}) return ST_SKIP;
    rstart = base;
    rlen   = len;
    // anything starting in the first mib is pulled down to zero, length saturates
    if (base <= LOW_MIB) begin
      rstart = '0;
      rlen   = end65[64] ? '1 : end65[63:0];
      end65  = {1'b0, rlen};
    end
    // crossing 4 gib: both halves are tried, either one failing flags overflow
    if (rstart < FOUR_GIB && end65 > {1'b0, FOUR_GIB}) begin
      below = FOUR_GIB - rstart;
      ok = table_insert(LOWER, rstart, below);
      if (!table_insert(UPPER, FOUR_GIB, rlen - below)) ok = 1'b0;
    end else begin
      ok = table_insert((rstart < FOUR_GIB) ? LOWER : UPPER, rstart, rlen);
    end
    return ok ? ST_OK : ST_OVERFLOW;
  endfunction

  // containment or next-start search, lower table first
  function automatic region_beat_t predict_lookup(input bit want_next, input logic [63:0] q);
    region_beat_t r;
    int           t;
    int           i;
    bit           hit;
    r.status    = ST_NOTFOUND;
    r.reg_start = '0;
    r.reg_len   = '0;
    for (t = LOWER; t <= UPPER; t++) begin
      for (i = 0; i < tab_cnt[t]; i++) begin
        if (want_next) hit = tab_start[t][i] > q;
        else hit = (q >= tab_start[t][i]) && (q - tab_start[t][i] < tab_len[t][i]);
        if (hit) begin
          r.status    = ST_OK;
          r.reg_start = tab_start[t][i];
          r.reg_len   = tab_len[t][i];
          return r;
        end
      end
    end
    return r;
  endfunction

  function automatic region_beat_t predict_region_cmd(input cmd_t c, input logic [63:0] base,
                                                      input logic [63:0] len,
                                                      input logic [31:0] typ,
                                                      input logic [63:0] q);
    region_beat_t r;
    r.status    = ST_SKIP;
    r.reg_start = '0;
    r.reg_len   = '0;
    case (c)
      CMD_ADD:  r.status = predict_add(base, len, typ);
      CMD_FIND: r = predict_lookup(1'b0, q);
      CMD_NEXT: r = predict_lookup(1'b1, q);
      default:  r.status = ST_SKIP;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------- checker

  // every result beat is matched against the oldest pending expectation;
  // an expectation taken at this very edge cannot be answered yet
  always @(posedge clk) begin : result_check
    region_beat_t want;
    if (rst_n && out_valid) begin
      if (pending_regions.size() == 0 || pending_regions[0].acc_cyc >= cyc) begin
        report_mismatch($sformatf("result beat with nothing pending, status %0d", out_status));
      end else begin
        want = pending_regions.pop_front();
        if (out_status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", out_status, want.status));
        if (out_region_start !== want.reg_start)
          report_mismatch($sformatf("region_start got %h want %h",
                                    out_region_start, want.reg_start));
        if (out_region_length !== want.reg_len)
          report_mismatch($sformatf("region_length got %h want %h",
                                    out_region_length, want.reg_len));
      end
    end
  end

  // ---------------------------------------------------------------- driving

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // one command beat: optional idle gap, then hold start until busy is seen low at an edge
  task automatic issue_cmd(input cmd_t c, input logic [63:0] base, input logic [63:0] len,
                           input logic [31:0] typ, input logic [63:0] q);
    region_beat_t r;
    int           gap;
    int           roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 55) gap = 0;
    else if (roll < 90) gap = $urandom_range(1, 4);
    else gap = $urandom_range(8, 60);
    // start is only lowered when a gap follows, never dropped and raised in one step
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_command    <= c;
    in_base_addr  <= base;
    in_region_len <= len;
    in_entry_type <= typ;
    in_query_addr <= q;
    @(posedge clk);
    while (busy) @(posedge clk);
    // taken at this edge: update the shadow tables and queue what should come back
    r = predict_region_cmd(c, base, len, typ, q);
    r.acc_cyc = cyc;
    pending_regions.push_back(r);
    items_sent++;
  endtask

  task automatic add_entry(input logic [63:0] base, input logic [63:0] len,
                           input logic [31:0] typ);
    issue_cmd(CMD_ADD, base, len, typ, rand64());
  endtask

  task automatic find_addr(input logic [63:0] q);
    issue_cmd(CMD_FIND, rand64(), rand64(), $urandom, q);
  endtask

  task automatic next_after(input logic [63:0] q);
    issue_cmd(CMD_NEXT, rand64(), rand64(), $urandom, q);
  endtask

  // base addresses clustered on the interesting boundaries, or reusing a known start
  function automatic logic [63:0] pick_base();
    int t;
    t = $urandom_range(LOWER, UPPER);
    case ($urandom_range(0, 7))
      0: return 64'($urandom_range(0, 32'h0010_0000));
      1: return LOW_MIB + 64'($urandom_range(0, 32'hffff));
      2: return {32'h0, $urandom};
      3: return FOUR_GIB - 64'($urandom_range(1, 32'hffff));
      4: return FOUR_GIB + {32'h0, $urandom};
      5: return rand64();
      6: return 64'hffff_ffff_ffff_ffff - 64'($urandom_range(0, 255));
      default: begin
        if (tab_cnt[t] == 0) return rand64();
        return tab_start[t][$urandom_range(0, tab_cnt[t] - 1)];
      end
    endcase
  endfunction

  function automatic logic [63:0] pick_len();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 64'($urandom_range(1, 32'h0001_0000));
      2: return {32'h0, $urandom};
      3: return rand64();
      4: return 64'hffff_ffff_ffff_ffff;
      default: return FOUR_GIB + 64'($urandom_range(0, 32'hffff));
    endcase
  endfunction

  // query addresses mostly right on or next to the edges of stored regions
  function automatic logic [63:0] pick_query();
    int          t;
    logic [63:0] s;
    logic [63:0] l;
    t = $urandom_range(LOWER, UPPER);
    if (tab_cnt[t] == 0 || $urandom_range(0, 3) == 0) return pick_base();
    s = tab_start[t][$urandom_range(0, tab_cnt[t] - 1)];
    l = tab_len[t][0];
    for (int i = 0; i < tab_cnt[t]; i++) if (tab_start[t][i] == s) l = tab_len[t][i];
    case ($urandom_range(0, 4))
      0: return s - 1;
      1: return s;
      2: return s + l - 1;
      3: return s + l;
      default: return (l == 0) ? s : s + (rand64() % l);
    endcase
  endfunction

  // ---------------------------------------------------------------- tests

  // lookups with both tables empty, and the unused command code
  task automatic test_empty_tables;
    find_addr('0);
    next_after('0);
    issue_cmd(CMD_NONE, 64'h2000_0000, 64'h1000, TYPE_USABLE, '0);
  endtask

  // entries the add filter must drop: wrong type, or ending inside the first mib
  task automatic test_entry_filter;
    add_entry(64'h2000_0000, 64'h1000, 32'h0);
    add_entry(64'h2000_0000, 64'h1000, 32'hffff_ffff);
    add_entry(64'h2000_0000, 64'h1000, 32'h2);
    add_entry('0, LOW_MIB, TYPE_USABLE);
    add_entry('0, '0, TYPE_USABLE);
  endtask

  // stretch to zero, saturation, splits at 4 gib, equal starts, zero length
  task automatic test_stretch_and_split;
    add_entry(64'hffff_ffff_ffff_ffff, 64'h1, TYPE_USABLE);   // end wraps past 2^64
    add_entry(64'h8_0000, 64'h10_0000, TYPE_USABLE);          // low start pulled to zero
    add_entry(LOW_MIB, 64'h1000, TYPE_USABLE);                // base exactly at 1 mib
    add_entry(64'h1000, 64'hffff_ffff_ffff_ffff, TYPE_USABLE); // saturate then split
    add_entry(64'h2000_0000, 64'h2000_0000, TYPE_USABLE);
    add_entry(64'hf000_0000, 64'h2000_0000, TYPE_USABLE);     // plain split
    add_entry(FOUR_GIB, '0, TYPE_USABLE);                     // zero length, upper table
    add_entry(64'hffff_ffff, 64'h1, TYPE_USABLE);             // ends exactly at 4 gib
  endtask

  task automatic test_lookups;
    find_addr(LOW_MIB);
    find_addr(FOUR_GIB);
    find_addr(64'hffff_ffff_ffff_ffff);
    next_after('0);
    next_after(64'hffff_ffff);
    next_after(64'hffff_ffff_ffff_ffff);
  endtask

  // mostly well-formed adds until both tables are full, lookups in between
  task automatic test_random_fill;
    int n;
    for (n = 0; n < 200; n++) begin
      if (tab_cnt[LOWER] == TABLE_DEPTH && tab_cnt[UPPER] == TABLE_DEPTH) break;
      if (n % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: add_entry(pick_base(), pick_len(), TYPE_USABLE);
        6:                add_entry(pick_base(), pick_len(), $urandom);
        7, 8:             find_addr(pick_query());
        default:          next_after(pick_query());
      endcase
    end
  endtask

  // full tables: lookups dominate, adds now run into overflow
  task automatic test_random_traffic;
    int n;
    n = 0;
    while (items_sent < TOTAL_ITEMS) begin
      if (n % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
      n++;
      case ($urandom_range(0, 19))
        0, 1:    add_entry(pick_base(), pick_len(), TYPE_USABLE);
        2:       add_entry(pick_base(), pick_len(), $urandom);
        3:       issue_cmd(CMD_NONE, rand64(), rand64(), $urandom, rand64());
        4, 5, 6, 7, 8, 9, 10, 11: find_addr(pick_query());
        default: next_after(pick_query());
      endcase
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    in_command    = CMD_NONE;
    in_base_addr  = '0;
    in_region_len = '0;
    in_entry_type = '0;
    in_query_addr = '0;
    tab_cnt[LOWER] = 0;
    tab_cnt[UPPER] = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_tables();
    test_entry_filter();
    test_stretch_and_split();
    test_lookups();
    test_random_fill();
    test_random_traffic();

    // drain: wait for every pending beat, then give stray beats time to show up
    start <= 1'b0;
    while (pending_regions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb_sorted_memory_region_table_top: clean");
    end else begin
      $display("tb_sorted_memory_region_table_top: errors");
    end
    $finish;
  end

endmodule
